/* rtl/x86d_pkg.sv */
package x86d_pkg;

    localparam int ADDR_W = 16;

    localparam logic [7:0] OP_SUB_R8_RM = 8'h2A;
    localparam logic [7:0] OP_JZ_REL8   = 8'h74;
    localparam logic [7:0] OP_GRP1_IMM8 = 8'h83;
    localparam logic [7:0] OP_MOV_R8_RM = 8'h8A;
    localparam logic [7:0] OP_MOV_R16   = 8'h8B;
    localparam logic [7:0] OP_MOV_SREG  = 8'h8E;
    localparam logic [7:0] OP_MOV_IMM8  = 8'hB0;
    localparam logic [7:0] OP_MOV_IMM8L = 8'hB7;
    localparam logic [7:0] OP_MOV_IMM16 = 8'hB8;
    localparam logic [7:0] OP_MOV_IM16L = 8'hBF;
    localparam logic [7:0] OP_INT_IMM8  = 8'hCD;
    localparam logic [7:0] OP_GRP2_ONE  = 8'hD1;
    localparam logic [7:0] OP_JMP_REL8  = 8'hEB;

    localparam logic [4:0] MN_ADD = 5'd0;
    localparam logic [4:0] MN_SUB = 5'd5;
    localparam logic [4:0] MN_MOV = 5'd8;
    localparam logic [4:0] MN_JZ  = 5'd9;
    localparam logic [4:0] MN_JMP = 5'd10;
    localparam logic [4:0] MN_INT = 5'd11;
    localparam logic [4:0] MN_ROL = 5'd12;

    localparam logic [2:0] OF_REG_RM  = 3'd0;
    localparam logic [2:0] OF_RM_IMM8 = 3'd1;
    localparam logic [2:0] OF_SREG_RM = 3'd2;
    localparam logic [2:0] OF_REG_IMM = 3'd3;
    localparam logic [2:0] OF_REL8    = 3'd4;
    localparam logic [2:0] OF_IMM8    = 3'd5;
    localparam logic [2:0] OF_RM_ONE  = 3'd6;

    localparam logic [1:0] ST_DECODED = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic [ADDR_W-1:0] start_address;
        logic [2:0]        byte_position;
        logic [7:0]        opcode;
        logic [7:0]        modrm;
        logic [15:0]       disp;
        logic [15:0]       imm;
        logic              halted;
    } t_dec_state;

    typedef struct packed {
        logic [15:0] instr_address;
        logic [4:0]  mnemonic;
        logic [2:0]  operand_form;
        logic        word_size;
        logic [2:0]  reg_number;
        logic [1:0]  rm_mode;
        logic [2:0]  rm_number;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [15:0] branch_target;
        logic [2:0]  instr_length;
        logic [1:0]  status;
    } t_dec_rec;

endpackage

/* rtl/x86d_step.sv */
module x86d_step (
    input  x86d_pkg::t_dec_state i_state,
    input  logic [7:0]           i_code_byte,
    input  logic                 i_end_of_code,
    output x86d_pkg::t_dec_state o_state,
    output x86d_pkg::t_dec_rec   o_rec,
    output logic                 o_rec_valid
);
    import x86d_pkg::*;

    typedef struct packed {
        logic       known;
        logic       has_m;
        logic [1:0] il;
    } t_class;

    function automatic t_class classify(input logic [7:0] op);
        t_class c;
        c = '0;
        unique case (op) inside
            OP_SUB_R8_RM, OP_MOV_R8_RM, OP_MOV_R16, OP_MOV_SREG, OP_GRP2_ONE: begin
                c.known = 1'b1;
                c.has_m = 1'b1;
            end
            OP_GRP1_IMM8: begin
                c.known = 1'b1;
                c.has_m = 1'b1;
                c.il    = 2'd1;
            end
            OP_JZ_REL8, OP_JMP_REL8, OP_INT_IMM8, [OP_MOV_IMM8:OP_MOV_IMM8L]: begin
                c.known = 1'b1;
                c.il    = 2'd1;
            end
            [OP_MOV_IMM16:OP_MOV_IM16L]: begin
                c.known = 1'b1;
                c.il    = 2'd2;
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] disp_length(input logic [7:0] m);
        logic [1:0] d;
        case (m[7:6])
            2'd1:    d = 2'd1;
            2'd2:    d = 2'd2;
            2'd0:    d = (m[2:0] == 3'd6) ? 2'd2 : 2'd0;
            default: d = 2'd0;
        endcase
        return d;
    endfunction

    function automatic logic [15:0] sext8(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

    t_class     w_cls;
    t_class     w_new_cls;
    logic [7:0] w_modrm;
    logic [1:0] w_dl;
    logic [2:0] w_dstart;
    logic [2:0] w_istart;
    logic [2:0] w_total;
    logic [2:0] w_p1;
    logic [2:0] w_dofs;
    logic [2:0] w_iofs;
    logic [15:0] w_disp;
    logic [15:0] w_imm;
    logic [2:0] w_regf;
    t_dec_rec   w_full;

    always_comb begin
        w_cls     = classify(i_state.opcode);
        w_new_cls = classify(i_code_byte);
        w_modrm   = (w_cls.has_m && i_state.byte_position == 3'd1) ? i_code_byte
                                                                   : i_state.modrm;
        w_dl      = w_cls.has_m ? disp_length(w_modrm) : 2'd0;
        w_dstart  = w_cls.has_m ? 3'd2 : 3'd1;
        w_istart  = w_dstart + {1'b0, w_dl};
        w_total   = w_istart + {1'b0, w_cls.il};
        w_p1      = i_state.byte_position + 3'd1;
        w_dofs    = i_state.byte_position - w_dstart;
        w_iofs    = i_state.byte_position - w_istart;
        w_disp    = i_state.disp;
        w_imm     = i_state.imm;
        if (!(w_cls.has_m && i_state.byte_position == 3'd1)) begin
            if (i_state.byte_position < w_istart) begin
                if (w_dofs[0]) w_disp = w_disp | {i_code_byte, 8'h00};
                else           w_disp = w_disp | {8'h00, i_code_byte};
            end else begin
                if (w_iofs[0]) w_imm = w_imm | {i_code_byte, 8'h00};
                else           w_imm = w_imm | {8'h00, i_code_byte};
            end
        end
        w_regf = w_modrm[5:3];

        w_full               = '0;
        w_full.instr_address = i_state.start_address[15:0];
        w_full.instr_length  = w_total;
        w_full.status        = ST_DECODED;
        if (w_cls.has_m) begin
            w_full.rm_mode   = w_modrm[7:6];
            w_full.rm_number = w_modrm[2:0];
            case (w_dl)
                2'd1:    w_full.displacement = sext8(w_disp[7:0]);
                2'd2:    w_full.displacement = w_disp;
                default: w_full.displacement = '0;
            endcase
        end
        unique case (i_state.opcode) inside
            OP_SUB_R8_RM, OP_MOV_R8_RM, OP_MOV_R16, OP_MOV_SREG: begin
                w_full.mnemonic     = (i_state.opcode == OP_SUB_R8_RM) ? MN_SUB : MN_MOV;
                w_full.operand_form = (i_state.opcode == OP_MOV_SREG) ? OF_SREG_RM
                                                                       : OF_REG_RM;
                w_full.word_size    = (i_state.opcode == OP_MOV_R16)
                                   || (i_state.opcode == OP_MOV_SREG);
                w_full.reg_number   = w_regf;
            end
            OP_GRP1_IMM8: begin
                w_full.mnemonic     = MN_ADD + {2'b00, w_regf};
                w_full.operand_form = OF_RM_IMM8;
                w_full.word_size    = 1'b1;
                w_full.immediate    = {8'h00, w_imm[7:0]};
            end
            OP_GRP2_ONE: begin
                w_full.mnemonic     = MN_ROL + {2'b00, w_regf};
                w_full.operand_form = OF_RM_ONE;
                w_full.word_size    = 1'b1;
                w_full.immediate    = 16'd1;
            end
            OP_JZ_REL8, OP_JMP_REL8: begin
                w_full.mnemonic      = (i_state.opcode == OP_JZ_REL8) ? MN_JZ : MN_JMP;
                w_full.operand_form  = OF_REL8;
                w_full.branch_target = i_state.start_address[15:0] + 16'd2
                                     + sext8(w_imm[7:0]);
            end
            OP_INT_IMM8: begin
                w_full.mnemonic     = MN_INT;
                w_full.operand_form = OF_IMM8;
                w_full.immediate    = {8'h00, w_imm[7:0]};
            end
            default: begin
                w_full.mnemonic     = MN_MOV;
                w_full.operand_form = OF_REG_IMM;
                w_full.word_size    = i_state.opcode >= OP_MOV_IMM16;
                w_full.reg_number   = i_state.opcode[2:0];
                w_full.immediate    = w_imm;
            end
        endcase

        o_state     = i_state;
        o_rec       = '0;
        o_rec_valid = 1'b0;
        o_rec.instr_address = i_state.start_address[15:0];
        if (!i_state.halted) begin
            if (i_state.byte_position == 3'd0) begin
                o_state.start_address = i_state.byte_address;
                o_state.opcode        = i_code_byte;
                o_state.modrm         = '0;
                o_state.disp          = '0;
                o_state.imm           = '0;
                o_rec.instr_address   = i_state.byte_address[15:0];
                o_rec.instr_length    = 3'd1;
                if (!w_new_cls.known) begin
                    o_rec.status   = ST_UNKNOWN;
                    o_state.halted = 1'b1;
                    o_rec_valid    = 1'b1;
                end else begin
                    o_state.byte_position = 3'd1;
                    o_rec.status          = ST_TRUNC;
                    o_rec_valid           = i_end_of_code;
                end
            end else begin
                o_state.modrm = w_modrm;
                o_state.disp  = w_disp;
                o_state.imm   = w_imm;
                if (w_p1 >= w_total) begin
                    o_rec                 = w_full;
                    o_rec_valid           = 1'b1;
                    o_state.byte_position = 3'd0;
                end else begin
                    o_state.byte_position = w_p1;
                    o_rec.instr_length    = w_p1;
                    o_rec.status          = ST_TRUNC;
                    o_rec_valid           = i_end_of_code;
                end
            end
        end
        o_state.byte_address = i_state.byte_address + ADDR_W'(1);
        if (i_end_of_code) begin
            o_state = '0;
        end
    end

endmodule

/* rtl/x86_subset_instruction_decoder_unit.sv */
// channel | direction | handshake                 | payload
// input   | in        | i_in_valid / o_in_ready   | i_code_byte, i_end_of_code
// result  | out       | o_out_valid / i_out_ready | o_instr_address .. o_status
//
// one code byte per cycle while not stalled; a byte is latched in the input
// register and then decoded against the collector state into the result register
// a record is valid once its last byte has passed the input and result registers
// reset clears the collector state and both valid flags at once
// a full result register stalls the input register and then the input port
module x86_subset_instruction_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_code_byte,
    input  logic        i_end_of_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_instr_address,
    output logic [4:0]  o_mnemonic,
    output logic [2:0]  o_operand_form,
    output logic        o_word_size,
    output logic [2:0]  o_reg_number,
    output logic [1:0]  o_rm_mode,
    output logic [2:0]  o_rm_number,
    output logic [15:0] o_displacement,
    output logic [15:0] o_immediate,
    output logic [15:0] o_branch_target,
    output logic [2:0]  o_instr_length,
    output logic [1:0]  o_status
);
    import x86d_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoc;
    t_dec_state r_st;
    t_dec_state n_st;
    t_dec_rec   n_rec;
    t_dec_rec   r_rec;
    logic       r_out_valid;
    logic       w_rec_valid;
    logic       w_advance;

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    x86d_step u_step (
        .i_state      (r_st),
        .i_code_byte  (r_in_byte),
        .i_end_of_code(r_in_eoc),
        .o_state      (n_st),
        .o_rec        (n_rec),
        .o_rec_valid  (w_rec_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_st <= n_st;
            end
            if (w_advance && w_rec_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_code_byte;
            r_in_eoc  <= i_end_of_code;
        end
        if (w_advance && w_rec_valid) begin
            r_rec <= n_rec;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_instr_address = r_rec.instr_address;
    assign o_mnemonic      = r_rec.mnemonic;
    assign o_operand_form  = r_rec.operand_form;
    assign o_word_size     = r_rec.word_size;
    assign o_reg_number    = r_rec.reg_number;
    assign o_rm_mode       = r_rec.rm_mode;
    assign o_rm_number     = r_rec.rm_number;
    assign o_displacement  = r_rec.displacement;
    assign o_immediate     = r_rec.immediate;
    assign o_branch_target = r_rec.branch_target;
    assign o_instr_length  = r_rec.instr_length;
    assign o_status        = r_rec.status;

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)
                                        && $stable(r_in_eoc)))
        else $error("input register lost a stalled byte");

    a_eoc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_eoc) |=> (r_st.byte_address == '0
                                     && r_st.byte_position == 3'd0 && !r_st.halted))
        else $error("collector not cleared after end of code");

    a_unknown_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_UNKNOWN) |-> (o_instr_length == 3'd1
                                                     && o_mnemonic == MN_ADD
                                                     && o_immediate == 16'd0))
        else $error("unknown opcode record carries decoded fields");

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_st.halted) |=> !($rose(r_out_valid)))
        else $error("record produced while halted");

endmodule

/* verif/tb_x86_subset_instruction_decoder_unit.sv */
module tb_x86_subset_instruction_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import x86d_pkg::*;

    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         PHASE_ITEMS  = 460;
    localparam int         HOLD_CYCLES  = 400;
    localparam logic [7:0] UNKNOWN_OP   = 8'h0F;

    class dec_scoreboard;
        logic [15:0] pc;
        logic [15:0] instr_start;
        logic [2:0]  pos;
        logic [7:0]  opcode;
        logic [7:0]  modrm;
        logic [15:0] disp_acc;
        logic [15:0] imm_acc;
        bit          halted;
        t_dec_rec    pending[$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            pc          = '0;
            instr_start = '0;
            pos         = '0;
            opcode      = '0;
            modrm       = '0;
            disp_acc    = '0;
            imm_acc     = '0;
            halted      = 1'b0;
        endfunction

        function void classify(input logic [7:0] op, output bit known, output bit has_m,
                               output int imm_n);
            known = 1'b1;
            has_m = 1'b0;
            imm_n = 0;
            case (op)
                OP_SUB_R8_RM, OP_MOV_R8_RM, OP_MOV_R16, OP_MOV_SREG, OP_GRP2_ONE: has_m = 1'b1;
                OP_GRP1_IMM8: begin
                    has_m = 1'b1;
                    imm_n = 1;
                end
                OP_JZ_REL8, OP_JMP_REL8, OP_INT_IMM8: imm_n = 1;
                default: begin
                    if (op >= OP_MOV_IMM8 && op <= OP_MOV_IMM8L) imm_n = 1;
                    else if (op >= OP_MOV_IMM16 && op <= OP_MOV_IM16L) imm_n = 2;
                    else known = 1'b0;
                end
            endcase
        endfunction

        function int disp_bytes(logic [7:0] m);
            case (m[7:6])
                2'd1: return 1;
                2'd2: return 2;
                2'd0: return (m[2:0] == 3'd6) ? 2 : 0;
                default: return 0;
            endcase
        endfunction

        function logic [15:0] sext8(logic [7:0] v);
            return {{8{v[7]}}, v};
        endfunction

        function t_dec_rec decode_record(int len);
            t_dec_rec   rec;
            logic [2:0] regf;
            bit         known;
            bit         has_m;
            int         imm_n;
            int         dl;
            rec  = '0;
            regf = modrm[5:3];
            classify(opcode, known, has_m, imm_n);
            dl = has_m ? disp_bytes(modrm) : 0;
            rec.instr_address = instr_start;
            rec.instr_length  = 3'(len);
            rec.status        = ST_DECODED;
            if (has_m) begin
                rec.rm_mode      = modrm[7:6];
                rec.rm_number    = modrm[2:0];
                rec.displacement = (dl == 1) ? sext8(disp_acc[7:0]) : (dl == 2) ? disp_acc : '0;
            end
            case (opcode)
                OP_SUB_R8_RM, OP_MOV_R8_RM, OP_MOV_R16, OP_MOV_SREG: begin
                    rec.mnemonic     = (opcode == OP_SUB_R8_RM) ? MN_SUB : MN_MOV;
                    rec.operand_form = (opcode == OP_MOV_SREG) ? OF_SREG_RM : OF_REG_RM;
                    rec.word_size    = (opcode == OP_MOV_R16 || opcode == OP_MOV_SREG);
                    rec.reg_number   = regf;
                end
                OP_GRP1_IMM8: begin
                    rec.mnemonic     = MN_ADD + 5'(regf);
                    rec.operand_form = OF_RM_IMM8;
                    rec.word_size    = 1'b1;
                    rec.immediate    = 16'(imm_acc[7:0]);
                end
                OP_GRP2_ONE: begin
                    rec.mnemonic     = MN_ROL + 5'(regf);
                    rec.operand_form = OF_RM_ONE;
                    rec.word_size    = 1'b1;
                    rec.immediate    = 16'd1;
                end
                OP_JZ_REL8, OP_JMP_REL8: begin
                    rec.mnemonic      = (opcode == OP_JZ_REL8) ? MN_JZ : MN_JMP;
                    rec.operand_form  = OF_REL8;
                    rec.branch_target = instr_start + 16'd2 + sext8(imm_acc[7:0]);
                end
                OP_INT_IMM8: begin
                    rec.mnemonic     = MN_INT;
                    rec.operand_form = OF_IMM8;
                    rec.immediate    = 16'(imm_acc[7:0]);
                end
                default: begin
                    rec.mnemonic     = MN_MOV;
                    rec.operand_form = OF_REG_IMM;
                    rec.word_size    = (opcode >= OP_MOV_IMM16);
                    rec.reg_number   = opcode[2:0];
                    rec.immediate    = imm_acc;
                end
            endcase
            return rec;
        endfunction

        function void push_short(logic [1:0] st, int len);
            t_dec_rec rec;
            rec               = '0;
            rec.instr_address = instr_start;
            rec.instr_length  = 3'(len);
            rec.status        = st;
            pending.push_back(rec);
        endfunction

        function void note_byte(logic [7:0] b, bit eoc);
            bit known;
            bit has_m;
            int imm_n;
            int p;
            int dl;
            int dstart;
            int istart;
            int total;
            if (!halted) begin
                if (pos == 0) begin
                    instr_start = pc;
                    opcode      = b;
                    modrm       = '0;
                    disp_acc    = '0;
                    imm_acc     = '0;
                    classify(b, known, has_m, imm_n);
                    if (!known) begin
                        push_short(ST_UNKNOWN, 1);
                        halted = 1'b1;
                    end else begin
                        pos = 3'd1;
                        if (eoc) push_short(ST_TRUNC, 1);
                    end
                end else begin
                    p = int'(pos);
                    classify(opcode, known, has_m, imm_n);
                    if (has_m && p == 1) modrm = b;
                    dl     = has_m ? disp_bytes(modrm) : 0;
                    dstart = has_m ? 2 : 1;
                    istart = dstart + dl;
                    total  = istart + imm_n;
                    if (!(has_m && p == 1)) begin
                        if (p < istart)
                            disp_acc = disp_acc | (16'(b) << (8 * ((p - dstart) & 1)));
                        else
                            imm_acc = imm_acc | (16'(b) << (8 * ((p - istart) & 1)));
                    end
                    p++;
                    if (p >= total) begin
                        pending.push_back(decode_record(total));
                        pos = '0;
                    end else begin
                        pos = 3'(p);
                        if (eoc) push_short(ST_TRUNC, p);
                    end
                end
            end
            pc = pc + 16'd1;
            if (eoc) clear();
        endfunction

        function void check_field(string name, logic [15:0] exp, logic [15:0] got);
            if (exp !== got) begin
                $error("%s: expected %0h, got %0h", name, exp, got);
                errors++;
            end
        endfunction

        function void check_record(t_dec_rec got);
            t_dec_rec exp;
            if (pending.size() == 0) begin
                $error("unexpected record at address %0h", got.instr_address);
                errors++;
                return;
            end
            exp = pending.pop_front();
            check_field("instr_address", exp.instr_address, got.instr_address);
            check_field("mnemonic",      16'(exp.mnemonic),     16'(got.mnemonic));
            check_field("operand_form",  16'(exp.operand_form), 16'(got.operand_form));
            check_field("word_size",     16'(exp.word_size),    16'(got.word_size));
            check_field("reg_number",    16'(exp.reg_number),   16'(got.reg_number));
            check_field("rm_mode",       16'(exp.rm_mode),      16'(got.rm_mode));
            check_field("rm_number",     16'(exp.rm_number),    16'(got.rm_number));
            check_field("displacement",  exp.displacement,  got.displacement);
            check_field("immediate",     exp.immediate,     got.immediate);
            check_field("branch_target", exp.branch_target, got.branch_target);
            check_field("instr_length",  16'(exp.instr_length), 16'(got.instr_length));
            check_field("status",        16'(exp.status),       16'(got.status));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_code_byte = '0;
    logic        i_end_of_code = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_instr_address;
    logic [4:0]  o_mnemonic;
    logic [2:0]  o_operand_form;
    logic        o_word_size;
    logic [2:0]  o_reg_number;
    logic [1:0]  o_rm_mode;
    logic [2:0]  o_rm_number;
    logic [15:0] o_displacement;
    logic [15:0] o_immediate;
    logic [15:0] o_branch_target;
    logic [2:0]  o_instr_length;
    logic [1:0]  o_status;

    dec_scoreboard sb = new();
    t_dec_rec      seen;
    logic [7:0]    instr_bytes[$];
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            items_done = 0;
    int            cycle_count = 0;
    int            hold_count = 0;
    logic          long_hold = 1'b0;

    x86_subset_instruction_decoder_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_code_byte     (i_code_byte),
        .i_end_of_code   (i_end_of_code),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_instr_address (o_instr_address),
        .o_mnemonic      (o_mnemonic),
        .o_operand_form  (o_operand_form),
        .o_word_size     (o_word_size),
        .o_reg_number    (o_reg_number),
        .o_rm_mode       (o_rm_mode),
        .o_rm_number     (o_rm_number),
        .o_displacement  (o_displacement),
        .o_immediate     (o_immediate),
        .o_branch_target (o_branch_target),
        .o_instr_length  (o_instr_length),
        .o_status        (o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: one long hold-off once requested, random stalls otherwise
    always @(posedge i_clk) begin
        if (long_hold && hold_count < HOLD_CYCLES) begin
            i_out_ready <= 1'b0;
            hold_count++;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = {o_instr_address, o_mnemonic, o_operand_form, o_word_size, o_reg_number,
                    o_rm_mode, o_rm_number, o_displacement, o_immediate, o_branch_target,
                    o_instr_length, o_status};
            sb.check_record(seen);
        end
    end

    task automatic send_seq(input logic [7:0] seq[$], input int eoc_at);
        for (int i = 0; i < seq.size(); i++) begin
            while ($urandom_range(99) < idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            if (!sb.halted) items_done++;
            i_in_valid    <= 1'b1;
            i_code_byte   <= seq[i];
            i_end_of_code <= (i == eoc_at);
            do @(posedge i_clk); while (!o_in_ready);
            sb.note_byte(seq[i], i == eoc_at);
        end
    endtask

    function automatic logic [7:0] pick_known();
        case ($urandom_range(10))
            0: return OP_SUB_R8_RM;
            1: return OP_JZ_REL8;
            2: return OP_GRP1_IMM8;
            3: return OP_MOV_R8_RM;
            4: return OP_MOV_R16;
            5: return OP_MOV_SREG;
            6: return OP_INT_IMM8;
            7: return OP_GRP2_ONE;
            8: return OP_JMP_REL8;
            9: return OP_MOV_IMM8 + 8'($urandom_range(7));
            default: return OP_MOV_IMM16 + 8'($urandom_range(7));
        endcase
    endfunction

    function automatic logic [7:0] pick_unknown();
        logic [7:0] b;
        bit         known;
        bit         has_m;
        int         imm_n;
        do begin
            b = 8'($urandom_range(255));
            sb.classify(b, known, has_m, imm_n);
        end while (known);
        return b;
    endfunction

    // fills instr_bytes with one well-formed instruction of random content
    function automatic void make_instr(logic [7:0] opc);
        bit         known;
        bit         has_m;
        int         imm_n;
        logic [7:0] m;
        instr_bytes = {};
        instr_bytes.push_back(opc);
        sb.classify(opc, known, has_m, imm_n);
        if (has_m) begin
            m = 8'($urandom_range(255));
            if ($urandom_range(5) == 0) m = {2'b00, m[5:3], 3'd6};
            instr_bytes.push_back(m);
            repeat (sb.disp_bytes(m)) instr_bytes.push_back(8'($urandom_range(255)));
        end
        repeat (imm_n) instr_bytes.push_back(8'($urandom_range(255)));
    endfunction

    task automatic run_stream();
        int         n;
        int         k;
        int         m;
        int         ending;
        logic [7:0] tail[$];
        n = $urandom_range(1, 10);
        repeat (n) begin
            make_instr(pick_known());
            send_seq(instr_bytes, -1);
        end
        ending = $urandom_range(99);
        if (ending < 45) begin
            make_instr(pick_known());
            send_seq(instr_bytes, instr_bytes.size() - 1);
        end else if (ending < 70) begin
            make_instr(pick_known());
            k = $urandom_range(instr_bytes.size() - 2);
            tail = instr_bytes[0:k];
            send_seq(tail, k);
        end else if (ending < 85) begin
            m = $urandom_range(4);
            tail = {pick_unknown()};
            repeat (m) tail.push_back(8'($urandom_range(255)));
            send_seq(tail, m);
        end else begin
            m = $urandom_range(1, 6);
            tail = {};
            repeat (m) tail.push_back(8'($urandom_range(255)));
            send_seq(tail, m - 1);
        end
    endtask

    task automatic run_phase(int idle, int stall, bit pressure);
        int target;
        idle_pct  = idle;
        stall_pct = stall;
        if (pressure) long_hold <= 1'b1;
        target = items_done + PHASE_ITEMS;
        while (items_done < target) run_stream();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_seq('{OP_JZ_REL8, 8'h80}, -1);
        send_seq('{OP_MOV_R8_RM, 8'hC0}, -1);
        send_seq('{OP_SUB_R8_RM, 8'h46, 8'h80}, -1);
        send_seq('{OP_MOV_R16, 8'h06, 8'hFF, 8'hFF}, -1);
        send_seq('{OP_MOV_SREG, 8'hD8}, -1);
        send_seq('{OP_GRP1_IMM8, 8'hF8, 8'hFF}, -1);
        send_seq('{OP_GRP2_ONE, 8'hF8}, -1);
        send_seq('{OP_JMP_REL8, 8'h7F}, -1);
        send_seq('{OP_INT_IMM8, 8'h21}, -1);
        send_seq('{OP_MOV_IMM16, 8'h34, 8'h12}, 2);
        send_seq('{OP_MOV_IMM16}, 0);
        send_seq('{OP_MOV_R16, 8'h86}, 1);
        send_seq('{UNKNOWN_OP, 8'hFF, 8'h00}, 2);

        run_phase(0, 0, 1'b1);
        run_phase(85, 0, 1'b0);
        run_phase(0, 85, 1'b0);
        run_phase(31, 31, 1'b0);
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/x86d_pkg.sv
rtl/x86d_step.sv
rtl/x86_subset_instruction_decoder_unit.sv
verif/tb_x86_subset_instruction_decoder_unit.sv
